/* sv/text_console_char_writer_macros.svh */
// Assertion macros shared by the console writer RTL.
`ifndef TEXT_CONSOLE_CHAR_WRITER_MACROS_SVH
`define TEXT_CONSOLE_CHAR_WRITER_MACROS_SVH

// Condition must hold at every clock edge out of reset.
`define TXC_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define TXC_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

/* sv/txc_pkg.sv */
// Shared constants, types and helper functions for the text console writer.
package txc_pkg;

	// Screen geometry
	localparam int COLUMNS   = 80;
	localparam int ROWS      = 25;
	localparam int TAB_STOP  = 8;
	localparam int CELLS     = COLUMNS * ROWS;
	localparam int TAB_COUNT = COLUMNS / TAB_STOP + 1;

	// Widths
	localparam int COL_W  = $clog2(COLUMNS);
	localparam int ROW_W  = $clog2(ROWS);
	localparam int CX_W   = $clog2(COLUMNS + TAB_STOP);
	localparam int RX_W   = $clog2(ROWS + 1);
	localparam int ADDR_W = $clog2(CELLS);
	localparam int CELL_W = 16;
	localparam int LOC_W  = 11;
	localparam int CI_W   = 11;

	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 32;
	localparam int OUT_PAD_W   = OUT_TDATA_W - LOC_W - CELL_W - 1;
	localparam int IN_PAD_W    = IN_TDATA_W - 2 - 8 - 8 - 8 - CI_W;

	// Opcodes
	localparam logic [1:0] OP_PUT    = 2'd0;
	localparam logic [1:0] OP_PUT_AT = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;
	localparam logic [1:0] OP_READ   = 2'd3;

	// Character codes
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DEL   = 8'h7F;

	localparam logic [7:0] KEEP_POS   = 8'hFF;
	localparam logic [7:0] ATTR_RESET = 8'd15;

	// Outcome of interpreting one character at a position
	typedef struct packed {
		logic              bad;
		logic              wr;
		logic              scroll;
		logic [ADDR_W-1:0] addr;
		logic [COL_W-1:0]  col;
		logic [ROW_W-1:0]  row;
	} emit_t;

	// Linear cell address of a row/column pair
	function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
			input logic [COL_W-1:0] c);
		cell_addr = ADDR_W'(r) * ADDR_W'(COLUMNS) + ADDR_W'(c);
	endfunction

	// Next tab stop strictly to the right of c
	function automatic logic [CX_W-1:0] tab_next(input logic [COL_W-1:0] c);
		logic [CX_W-1:0] res;
		int              k;
		res = '0;
		// Walk stops from the far right down; the nearest one wins.
		for (k = TAB_COUNT; k >= 1; k--) begin
			if (k * TAB_STOP > int'(c))
				res = CX_W'(k * TAB_STOP);
		end
		tab_next = res;
	endfunction

endpackage

/* sv/text_console_char_writer.sv */
// Top level of the text console writer: command sequencer around the screen RAM.
// A new command is accepted only in the idle state, after the previous one has finished.
// Scroll copies one cell per cycle through the RAM read port, then blanks the last row.
// After reset a clearing pass zeroes every screen cell; tready stays low meanwhile.
`include "text_console_char_writer_macros.svh"

module text_console_char_writer import txc_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	// opcode[1:0], char_code[9:2], col[17:10], row[25:18], cell_index[36:26]
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// cursor_location[10:0], cell_data[26:11], bad_position[27]
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	input  logic                   attribute_we,
	input  logic [7:0]             attribute_wdata
);

	localparam logic [2:0] ST_INIT   = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_EXEC   = 3'd2;
	localparam logic [2:0] ST_READ   = 3'd3;
	localparam logic [2:0] ST_SCROLL = 3'd4;
	localparam logic [2:0] ST_DRAIN  = 3'd5;
	localparam logic [2:0] ST_FILL   = 3'd6;
	localparam logic [2:0] ST_RESP   = 3'd7;

	localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);

	logic [2:0]        state_q, state_d;
	logic [ADDR_W-1:0] cnt_q, cnt_d;
	logic [COL_W-1:0]  cur_col_q, cur_col_d;
	logic [ROW_W-1:0]  cur_row_q, cur_row_d;
	logic [7:0]        attr_q;

	logic [1:0]        op_q;
	logic [7:0]        ch_q;
	logic [7:0]        pc_q;
	logic [7:0]        pr_q;
	logic [CI_W-1:0]   ci_q;

	logic [CELL_W-1:0] data_q, data_d;
	logic              bad_q, bad_d;

	logic              cp_vld_s1, cp_vld_d;
	logic [ADDR_W-1:0] cp_addr_s1, cp_addr_d;

	logic              out_valid_q;
	logic [LOC_W-1:0]  out_loc_q;
	logic [CELL_W-1:0] out_data_q;
	logic              out_bad_q;

	logic              accept;
	logic              out_free;
	logic              load_out;
	logic              finish;
	logic [LOC_W-1:0]  loc_d;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [CELL_W-1:0] ram_wdata;
	logic [ADDR_W-1:0] ram_raddr;
	logic [CELL_W-1:0] ram_rdata;

	emit_t             em;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;

	txc_emit u_emit (
		.put_at    (op_q == OP_PUT_AT),
		.char_code (ch_q),
		.col       (pc_q),
		.row       (pr_q),
		.cur_col   (cur_col_q),
		.cur_row   (cur_row_q),
		.res       (em)
	);

	txc_ram #(
		.WIDTH (CELL_W),
		.DEPTH (CELLS)
	) u_screen (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_addr (ram_raddr),
		.rd_data (ram_rdata)
	);

	// Cursor update: plain put moves it, clear homes it, put-at leaves it
	always_comb begin
		cur_col_d = cur_col_q;
		cur_row_d = cur_row_q;
		if (state_q == ST_EXEC) begin
			if (op_q == OP_PUT) begin
				cur_col_d = em.col;
				cur_row_d = em.row;
			end else if (op_q == OP_CLEAR) begin
				cur_col_d = '0;
				cur_row_d = ROW_W'(1);
			end
		end
	end

	assign loc_d = LOC_W'(cell_addr(cur_row_d, cur_col_d));

	// Sequencer and RAM port steering
	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		data_d    = data_q;
		bad_d     = bad_q;
		load_out  = 1'b0;
		finish    = 1'b0;
		cp_vld_d  = 1'b0;
		cp_addr_d = cp_addr_s1;
		ram_raddr = ADDR_W'(ci_q);
		ram_we    = 1'b0;
		ram_waddr = cnt_q;
		ram_wdata = '0;
		unique case (state_q)
			ST_INIT: begin
				ram_we = 1'b1;
				if (cnt_q == LAST_CELL) begin
					cnt_d   = '0;
					state_d = ST_IDLE;
				end else begin
					cnt_d = cnt_q + ADDR_W'(1);
				end
			end
			ST_IDLE: begin
				if (accept)
					state_d = ST_EXEC;
			end
			ST_EXEC: begin
				data_d = '0;
				bad_d  = em.bad;
				unique case (op_q)
					OP_PUT, OP_PUT_AT: begin
						ram_we    = em.wr;
						ram_waddr = em.addr;
						ram_wdata = {attr_q, ch_q};
						if (em.scroll) begin
							cnt_d   = ADDR_W'(2 * COLUMNS);
							state_d = ST_SCROLL;
						end else begin
							finish = 1'b1;
						end
					end
					OP_CLEAR: begin
						cnt_d   = ADDR_W'(COLUMNS);
						state_d = ST_FILL;
					end
					OP_READ: begin
						if (int'(ci_q) < CELLS)
							state_d = ST_READ;
						else
							finish = 1'b1;
					end
				endcase
				if (finish) begin
					if (out_free) begin
						load_out = 1'b1;
						state_d  = ST_IDLE;
					end else begin
						state_d = ST_RESP;
					end
				end
			end
			ST_READ: begin
				data_d  = ram_rdata;
				state_d = ST_RESP;
			end
			ST_SCROLL: begin
				// Read one row ahead; the copy is written back in the following cycle
				ram_raddr = cnt_q;
				cp_vld_d  = 1'b1;
				cp_addr_d = cnt_q - ADDR_W'(COLUMNS);
				if (cnt_q == LAST_CELL)
					state_d = ST_DRAIN;
				else
					cnt_d = cnt_q + ADDR_W'(1);
			end
			ST_DRAIN: begin
				cnt_d   = ADDR_W'((ROWS - 1) * COLUMNS);
				state_d = ST_FILL;
			end
			ST_FILL: begin
				ram_we    = 1'b1;
				ram_wdata = {attr_q, CH_SPACE};
				if (cnt_q == LAST_CELL)
					state_d = ST_RESP;
				else
					cnt_d = cnt_q + ADDR_W'(1);
			end
			ST_RESP: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
		endcase
		// Pending scroll copy owns the write port
		if (cp_vld_s1) begin
			ram_we    = 1'b1;
			ram_waddr = cp_addr_s1;
			ram_wdata = ram_rdata;
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			cnt_q       <= '0;
			cur_col_q   <= '0;
			cur_row_q   <= ROW_W'(1);
			attr_q      <= ATTR_RESET;
			cp_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			cnt_q     <= cnt_d;
			cur_col_q <= cur_col_d;
			cur_row_q <= cur_row_d;
			cp_vld_s1 <= cp_vld_d;
			if (attribute_we)
				attr_q <= attribute_wdata;
			if (load_out)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		cp_addr_s1 <= cp_addr_d;
		data_q     <= data_d;
		bad_q      <= bad_d;
		if (accept) begin
			op_q <= s_axis_tdata[1:0];
			ch_q <= s_axis_tdata[9:2];
			pc_q <= s_axis_tdata[17:10];
			pr_q <= s_axis_tdata[25:18];
			ci_q <= s_axis_tdata[36:26];
		end
		if (load_out) begin
			out_loc_q  <= loc_d;
			out_data_q <= data_d;
			out_bad_q  <= bad_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {OUT_PAD_W'(0), out_bad_q, out_data_q, out_loc_q};

	// Cursor never leaves the text area
	`TXC_ASSERT_ALWAYS(a_cursor_range, cur_row_q >= ROW_W'(1) && int'(cur_row_q) < ROWS && int'(cur_col_q) < COLUMNS, "cursor outside text area")

	// Copy write address trails the scroll read address by exactly one row plus one cell
	`TXC_ASSERT_IMPLY(a_copy_lag, cp_vld_s1 && state_q == ST_SCROLL, cnt_q == cp_addr_s1 + ADDR_W'(COLUMNS + 1), "scroll copy out of step")

	// Copies only land in rows 1 to ROWS-2
	`TXC_ASSERT_IMPLY(a_copy_rows, cp_vld_s1, cp_addr_s1 >= ADDR_W'(COLUMNS) && int'(cp_addr_s1) < (ROWS - 1) * COLUMNS, "scroll copy hits fixed or last row")

	// Blank fill never touches the status row
	`TXC_ASSERT_IMPLY(a_fill_rows, state_q == ST_FILL, cnt_q >= ADDR_W'(COLUMNS), "blank fill in status row")

endmodule

/* sv/txc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module txc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
	end

	// Read port, registered read data
	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

/* sv/txc_emit.sv */
// Character interpreter: cursor motion, cell write and scroll decision.
module txc_emit import txc_pkg::*; (
	input  logic             put_at,
	input  logic [7:0]       char_code,
	input  logic [7:0]       col,
	input  logic [7:0]       row,
	input  logic [COL_W-1:0] cur_col,
	input  logic [ROW_W-1:0] cur_row,
	output emit_t            res
);

	logic             col_keep;
	logic             row_keep;
	logic             bad;
	logic             wr;
	logic [COL_W-1:0] c0;
	logic [ROW_W-1:0] r0;
	logic [CX_W-1:0]  c1;
	logic [RX_W-1:0]  r1;
	logic             scroll;

	// Position check and start position
	always_comb begin
		col_keep = (col == KEEP_POS);
		row_keep = (row == KEEP_POS);
		bad = put_at && ((!col_keep && col >= 8'(COLUMNS)) ||
			(!row_keep && row >= 8'(ROWS)));
		c0 = (put_at && !col_keep) ? col[COL_W-1:0] : cur_col;
		r0 = (put_at && !row_keep) ? row[ROW_W-1:0] : cur_row;
	end

	// Character action, then wrap and scroll
	always_comb begin
		c1 = CX_W'(c0);
		r1 = RX_W'(r0);
		wr = 1'b0;
		unique case (char_code)
			CH_BS: begin
				if (c0 != '0)
					c1 = CX_W'(c0) - CX_W'(1);
			end
			CH_TAB: c1 = tab_next(c0);
			CH_CR:  c1 = '0;
			CH_LF: begin
				c1 = '0;
				r1 = r1 + RX_W'(1);
			end
			default: begin
				if (char_code >= CH_SPACE && char_code <= CH_DEL) begin
					wr = 1'b1;
					c1 = CX_W'(c0) + CX_W'(1);
				end
			end
		endcase
		if (c1 >= CX_W'(COLUMNS)) begin
			c1 = '0;
			r1 = r1 + RX_W'(1);
		end
		scroll = (r1 >= RX_W'(ROWS));
	end

	assign res.bad    = bad;
	assign res.wr     = wr && !bad;
	assign res.scroll = scroll && !bad;
	assign res.addr   = cell_addr(r0, c0);
	assign res.col    = COL_W'(c1);
	assign res.row    = scroll ? ROW_W'(ROWS - 1) : ROW_W'(r1);

endmodule
